// File: rtl/stpt_pkg.sv
// ----------------------------------------------------------------------------
// stpt_pkg
// Shared widths, constants and the arctangent table for the stylus tilt core.
// ----------------------------------------------------------------------------
package stpt_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    // rotation datapath widths
    localparam int RW = 34;   // x, y of the sine/cosine units
    localparam int RZ = 32;   // residual angle of the sine/cosine units
    // vectoring datapath widths
    localparam int VW = 35;   // x, y of the arctangent units
    localparam int VZ = 33;   // accumulated angle of the arctangent units

    localparam int ANG_SHIFT = 16;
    localparam logic signed [RW-1:0] KSCALE = 34'sd652032874;
    localparam logic signed [VZ-1:0] OFF_180 = 33'sd1179648000;   // 18000 << 16
    localparam logic signed [VZ:0]   ANG_90  = 34'sd589824000;    // 9000 << 16

    // side data that travels beside the angle pipeline
    typedef struct packed {
        logic        touch;
        logic        pen;
        logic        eraser;
        logic        button;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [11:0] press;
        logic [15:0] tstamp;
        logic        tilt_en;
        logic        neg_alt;
        logic        neg_azm;
    } t_side;

    // arctangent of 2^-i in centidegrees << 16
    function automatic logic signed [31:0] atan_tab(input int idx);
        logic signed [31:0] v;
        case (idx)
            0:  v = 32'sd294912000;
            1:  v = 32'sd174096719;
            2:  v = 32'sd91987925;
            3:  v = 32'sd46694507;
            4:  v = 32'sd23437865;
            5:  v = 32'sd11730358;
            6:  v = 32'sd5866610;
            7:  v = 32'sd2933484;
            8:  v = 32'sd1466764;
            9:  v = 32'sd733385;
            10: v = 32'sd366693;
            11: v = 32'sd183346;
            12: v = 32'sd91673;
            13: v = 32'sd45837;
            14: v = 32'sd22918;
            15: v = 32'sd11459;
            16: v = 32'sd5730;
            17: v = 32'sd2865;
            18: v = 32'sd1432;
            19: v = 32'sd716;
            20: v = 32'sd358;
            21: v = 32'sd179;
            22: v = 32'sd90;
            23: v = 32'sd45;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/stpt_sincos.sv
// ----------------------------------------------------------------------------
// stpt_sincos
// Pipelined rotation-mode CORDIC, one iteration per register stage.
// ----------------------------------------------------------------------------
module stpt_sincos #(
    parameter int STEPS = stpt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [15:0]               i_ang,
    output logic signed [stpt_pkg::RW-1:0]   o_cos,
    output logic signed [stpt_pkg::RW-1:0]   o_sin
);
    import stpt_pkg::*;

    logic signed [RW-1:0] r_x [STEPS];
    logic signed [RW-1:0] r_y [STEPS];
    logic signed [RZ-1:0] r_z [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_stage
            logic signed [RW-1:0] w_x;
            logic signed [RW-1:0] w_y;
            logic signed [RZ-1:0] w_z;
            logic signed [RW-1:0] n_x;
            logic signed [RW-1:0] n_y;
            logic signed [RZ-1:0] n_z;

            // stage input: initial vector or previous stage
            if (k == 0) begin : g_first
                assign w_x = KSCALE;
                assign w_y = '0;
                assign w_z = RZ'({{(RZ-16){i_ang[15]}}, i_ang} <<< ANG_SHIFT);
            end else begin : g_next
                assign w_x = r_x[k-1];
                assign w_y = r_y[k-1];
                assign w_z = r_z[k-1];
            end

            // one micro-rotation
            always_comb begin
                if (w_z >= 0) begin
                    n_x = w_x - (w_y >>> k);
                    n_y = w_y + (w_x >>> k);
                    n_z = w_z - atan_tab(k);
                end else begin
                    n_x = w_x + (w_y >>> k);
                    n_y = w_y - (w_x >>> k);
                    n_z = w_z + atan_tab(k);
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k] <= n_x;
                    r_y[k] <= n_y;
                    r_z[k] <= n_z;
                end
            end
        end
    endgenerate

    assign o_cos = r_x[STEPS-1];
    assign o_sin = r_y[STEPS-1];

endmodule

// File: rtl/stpt_atan2.sv
// ----------------------------------------------------------------------------
// stpt_atan2
// Pipelined vectoring-mode CORDIC giving atan2(y, x) in centidegrees << 16.
// ----------------------------------------------------------------------------
module stpt_atan2 #(
    parameter int STEPS = stpt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [31:0]               i_y,
    input  logic signed [stpt_pkg::RW-1:0]   i_x,
    output logic signed [stpt_pkg::VZ-1:0]   o_ang
);
    import stpt_pkg::*;

    logic signed [VW-1:0] w_y0;
    logic signed [VW-1:0] w_x0;
    logic signed [VW-1:0] r_px;
    logic signed [VW-1:0] r_py;
    logic signed [VZ-1:0] r_pz;
    logic                 r_pzero;

    logic signed [VW-1:0] r_x  [STEPS];
    logic signed [VW-1:0] r_y  [STEPS];
    logic signed [VZ-1:0] r_z  [STEPS];
    logic                 r_zero [STEPS];

    assign w_y0 = VW'(i_y);
    assign w_x0 = VW'(i_x);

    // left half-plane fold and start angle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pzero <= (w_x0 == '0) && (w_y0 == '0);
            if (w_x0 < 0) begin
                r_px <= -w_x0;
                r_py <= -w_y0;
                r_pz <= (w_y0 >= 0) ? OFF_180 : -OFF_180;
            end else begin
                r_px <= w_x0;
                r_py <= w_y0;
                r_pz <= '0;
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_stage
            logic signed [VW-1:0] w_x;
            logic signed [VW-1:0] w_y;
            logic signed [VZ-1:0] w_z;
            logic                 w_zero;
            logic signed [VW-1:0] n_x;
            logic signed [VW-1:0] n_y;
            logic signed [VZ-1:0] n_z;

            if (k == 0) begin : g_first
                assign w_x    = r_px;
                assign w_y    = r_py;
                assign w_z    = r_pz;
                assign w_zero = r_pzero;
            end else begin : g_next
                assign w_x    = r_x[k-1];
                assign w_y    = r_y[k-1];
                assign w_z    = r_z[k-1];
                assign w_zero = r_zero[k-1];
            end

            // one micro-rotation toward the x axis
            always_comb begin
                if (w_y > 0) begin
                    n_x = w_x + (w_y >>> k);
                    n_y = w_y - (w_x >>> k);
                    n_z = w_z + VZ'(atan_tab(k));
                end else begin
                    n_x = w_x - (w_y >>> k);
                    n_y = w_y + (w_x >>> k);
                    n_z = w_z - VZ'(atan_tab(k));
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k]    <= n_x;
                    r_y[k]    <= n_y;
                    r_z[k]    <= n_z;
                    r_zero[k] <= w_zero;
                end
            end
        end
    endgenerate

    // both operands zero give a zero angle
    assign o_ang = r_zero[STEPS-1] ? '0 : r_z[STEPS-1];

endmodule

// File: rtl/stylus_sample_to_tilt_events_core.sv
// ----------------------------------------------------------------------------
// stylus_sample_to_tilt_events_core
// Turns one stylus sample into pen flags, position, pressure and tilt angles.
// ----------------------------------------------------------------------------
// Input channel: i_valid with the sample fields, o_stall back to the sender.
// Output channel: o_valid with the event fields, i_stall from the receiver.
// A request is taken on an edge with valid high and stall low.
// Throughput: one request per cycle, sustained while the receiver does not stall.
// Pipeline: an input register, two chains of CORDIC stages for sine/cosine of
// altitude and azimuth, a product stage, a half-plane fold stage, then two
// arctangent chains and a final subtract and truncate stage.
// The tilt is computed only in proximity, with altitude above zero and not in
// legacy format; otherwise both tilts are zero. Legacy samples get pressure
// times four (saturating at 4095) and a zero timestamp.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_stall rises; nothing is dropped or repeated. Bubbles still move while the
// output register is empty.
// Reset clears every valid bit; the data registers are not reset.
// ----------------------------------------------------------------------------
module stylus_sample_to_tilt_events_core #(
    parameter int CORDIC_STEPS = stpt_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_legacy_format,
    input  logic [3:0]         i_mode_bits,
    input  logic [15:0]        i_in_x,
    input  logic [15:0]        i_in_y,
    input  logic [11:0]        i_in_pressure,
    input  logic [13:0]        i_altitude,
    input  logic [15:0]        i_azimuth,
    input  logic [15:0]        i_in_timestamp,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_pen_touch,
    output logic               o_tool_pen,
    output logic               o_tool_eraser,
    output logic               o_barrel_button,
    output logic [15:0]        o_pos_x,
    output logic [15:0]        o_pos_y,
    output logic [11:0]        o_pen_pressure,
    output logic [15:0]        o_time_stamp,
    output logic signed [14:0] o_tilt_x,
    output logic signed [14:0] o_tilt_y
);
    import stpt_pkg::*;

    localparam int LAT = 2 * CORDIC_STEPS + 4;

    logic                 w_en;
    logic [LAT-1:0]       r_vld;
    t_side                r_side [LAT];
    t_side                n_side;

    logic [13:0]          w_alt;
    logic [15:0]          w_azm;
    logic signed [16:0]   w_azs;
    logic signed [15:0]   n_alt_a;
    logic signed [15:0]   n_azm_a;
    logic                 n_neg_azm;
    logic signed [15:0]   r_alt_a;
    logic signed [15:0]   r_azm_a;

    logic signed [RW-1:0] w_ca;
    logic signed [RW-1:0] w_sa;
    logic signed [RW-1:0] w_cz;
    logic signed [RW-1:0] w_sz;
    logic signed [31:0]   w_ca_n;
    logic signed [31:0]   w_sa_n;
    logic signed [31:0]   w_cz_n;
    logic signed [31:0]   w_sz_n;
    logic signed [63:0]   w_prx;
    logic signed [63:0]   w_pry;
    logic signed [31:0]   r_ca;
    logic signed [RW-1:0] r_px;
    logic signed [RW-1:0] r_py;

    logic signed [VZ-1:0] w_ax;
    logic signed [VZ-1:0] w_ay;
    logic signed [VZ:0]   w_vx;
    logic signed [VZ:0]   w_vy;
    logic signed [VZ:0]   w_tx;
    logic signed [VZ:0]   w_ty;
    logic signed [14:0]   r_tx;
    logic signed [14:0]   r_ty;

    // whole pipeline holds only while a finished result is stalled
    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // input decode, legacy handling and angle range reduction
    always_comb begin
        w_alt = i_legacy_format ? 14'd0 : i_altitude;
        w_azm = i_legacy_format ? 16'd0 : i_azimuth;
        if (w_alt > 14'd9000) begin
            w_alt = 14'd9000;
        end
        if (w_azm >= 16'd36000) begin
            w_azm = w_azm - 16'd36000;
        end
        w_azs = (w_azm > 16'd18000) ? $signed({1'b0, w_azm}) - 17'sd36000
                                    : $signed({1'b0, w_azm});
        n_neg_azm = 1'b0;
        if (w_azs > 17'sd9000) begin
            w_azs     = w_azs - 17'sd18000;
            n_neg_azm = 1'b1;
        end else if (w_azs < -17'sd9000) begin
            w_azs     = w_azs + 17'sd18000;
            n_neg_azm = 1'b1;
        end
        n_azm_a = w_azs[15:0];
        n_alt_a = $signed({2'b00, w_alt});

        n_side.touch   = i_mode_bits[1];
        n_side.pen     = i_mode_bits[0] & ~i_mode_bits[3];
        n_side.eraser  = i_mode_bits[0] & i_mode_bits[3];
        n_side.button  = i_mode_bits[2];
        n_side.pos_x   = i_in_x;
        n_side.pos_y   = i_in_y;
        if (i_legacy_format) begin
            n_side.press = (i_in_pressure[11:10] != 2'b00) ? 12'd4095
                                                            : {i_in_pressure[9:0], 2'b00};
        end else begin
            n_side.press = i_in_pressure;
        end
        n_side.tstamp  = i_legacy_format ? 16'd0 : i_in_timestamp;
        n_side.tilt_en = i_mode_bits[0] & (w_alt != 14'd0);
        n_side.neg_alt = 1'b0;
        n_side.neg_azm = n_neg_azm;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_alt_a <= n_alt_a;
            r_azm_a <= n_azm_a;
        end
    end

    // side data delay line
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side;
            for (int j = 1; j < LAT; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    // sine and cosine of both angles
    stpt_sincos #(.STEPS(CORDIC_STEPS)) u_alt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (r_alt_a),
        .o_cos (w_ca),
        .o_sin (w_sa)
    );

    stpt_sincos #(.STEPS(CORDIC_STEPS)) u_azm (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (r_azm_a),
        .o_cos (w_cz),
        .o_sin (w_sz)
    );

    // quadrant sign fix, cosine clamp and horizontal projection products
    always_comb begin
        w_ca_n = r_side[CORDIC_STEPS].neg_alt ? -w_ca[31:0] : w_ca[31:0];
        w_sa_n = r_side[CORDIC_STEPS].neg_alt ? -w_sa[31:0] : w_sa[31:0];
        w_cz_n = r_side[CORDIC_STEPS].neg_azm ? -w_cz[31:0] : w_cz[31:0];
        w_sz_n = r_side[CORDIC_STEPS].neg_azm ? -w_sz[31:0] : w_sz[31:0];
        if (w_ca_n < 0) begin
            w_ca_n = '0;
        end
        w_prx = 64'(w_sa_n) * 64'(w_cz_n);
        w_pry = 64'(w_sa_n) * 64'(w_sz_n);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ca <= w_ca_n;
            r_px <= RW'(w_prx >>> 30);
            r_py <= RW'(w_pry >>> 30);
        end
    end

    // arctangent units
    stpt_atan2 #(.STEPS(CORDIC_STEPS)) u_atx (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_ca),
        .i_x   (r_px),
        .o_ang (w_ax)
    );

    stpt_atan2 #(.STEPS(CORDIC_STEPS)) u_aty (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_ca),
        .i_x   (r_py),
        .o_ang (w_ay)
    );

    // offset from vertical and truncation toward zero
    always_comb begin
        w_vx = ANG_90 - (VZ+1)'(w_ax);
        w_vy = (VZ+1)'(w_ay) - ANG_90;
        w_tx = (w_vx < 0) ? -((-w_vx) >>> ANG_SHIFT) : (w_vx >>> ANG_SHIFT);
        w_ty = (w_vy < 0) ? -((-w_vy) >>> ANG_SHIFT) : (w_vy >>> ANG_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tx <= r_side[LAT-2].tilt_en ? w_tx[14:0] : 15'sd0;
            r_ty <= r_side[LAT-2].tilt_en ? w_ty[14:0] : 15'sd0;
        end
    end

    // output register
    assign o_valid         = r_vld[LAT-1];
    assign o_pen_touch     = r_side[LAT-1].touch;
    assign o_tool_pen      = r_side[LAT-1].pen;
    assign o_tool_eraser   = r_side[LAT-1].eraser;
    assign o_barrel_button = r_side[LAT-1].button;
    assign o_pos_x         = r_side[LAT-1].pos_x;
    assign o_pos_y         = r_side[LAT-1].pos_y;
    assign o_pen_pressure  = r_side[LAT-1].press;
    assign o_time_stamp    = r_side[LAT-1].tstamp;
    assign o_tilt_x        = r_tx;
    assign o_tilt_y        = r_ty;

endmodule

// File: tb/stylus_sample_to_tilt_events_core_tb.sv
// ----------------------------------------------------------------------------
// stylus_sample_to_tilt_events_core_tb
// Drives stylus samples through the tilt core with random gaps and receiver
// stalls, predicts each event record with a bit-exact fixed-point CORDIC
// model and compares every field of every result in order.
// ----------------------------------------------------------------------------
module stylus_sample_to_tilt_events_core_tb;

    localparam int STEPS     = 16;
    localparam int LATENCY   = 2 * STEPS + 4;
    localparam int WDOG_MAX  = 20000;
    localparam longint ANG_ONE = 65536;
    localparam longint KSC     = 652032874;
    localparam int MODE_PROX   = 0;
    localparam int MODE_TOUCH  = 1;
    localparam int MODE_BUTTON = 2;
    localparam int MODE_ERASER = 3;

    typedef struct {
        logic        legacy;
        logic [3:0]  mode;
        logic [15:0] x;
        logic [15:0] y;
        logic [11:0] press;
        logic [13:0] alt;
        logic [15:0] azm;
        logic [15:0] ts;
    } t_sample;

    typedef struct {
        logic        touch;
        logic        pen;
        logic        eraser;
        logic        button;
        logic [15:0] x;
        logic [15:0] y;
        logic [11:0] press;
        logic [15:0] ts;
        logic [14:0] tx;
        logic [14:0] ty;
    } t_event;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic        i_legacy_format;
    logic [3:0]  i_mode_bits;
    logic [15:0] i_in_x, i_in_y, i_azimuth, i_in_timestamp;
    logic [11:0] i_in_pressure;
    logic [13:0] i_altitude;
    logic o_pen_touch, o_tool_pen, o_tool_eraser, o_barrel_button;
    logic [15:0] o_pos_x, o_pos_y, o_time_stamp;
    logic [11:0] o_pen_pressure;
    logic signed [14:0] o_tilt_x, o_tilt_y;

    t_event expected_events[$];
    int     n_errors;
    int     n_sent;
    int     n_checked;
    int     n_tilted;
    int     idle_cycles;
    bit     stall_hold;      // long receiver hold-off in progress
    bit     stall_quiet;     // receiver never stalls
    bit     gap_quiet;       // sender never idles

    longint atan_table[24] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346,
        91673, 45837, 22918, 11459, 5730, 2865,
        1432, 716, 358, 179, 90, 45
    };

    stylus_sample_to_tilt_events_core #(.CORDIC_STEPS(STEPS)) DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // arithmetic shift right, floor rounding
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    // sine and cosine of a centidegree angle, scaled by 2^30
    function automatic void sin_cos(longint cd, output longint c, output longint s);
        longint a, z, x, y, nx, ny;
        bit     flip;
        a = cd % 36000;
        flip = 1'b0;
        if (a > 18000) a -= 36000;
        if (a > 9000) begin
            a -= 18000;
            flip = 1'b1;
        end else if (a < -9000) begin
            a += 18000;
            flip = 1'b1;
        end
        z = a * ANG_ONE;
        x = KSC;
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                nx = x - shr_floor(y, i);
                ny = y + shr_floor(x, i);
                z -= atan_table[i];
            end else begin
                nx = x + shr_floor(y, i);
                ny = y - shr_floor(x, i);
                z += atan_table[i];
            end
            x = nx;
            y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // angle of (x, y) in centidegrees << 16
    function automatic longint arc_tan2(longint y, longint x);
        longint off, z, nx, ny;
        off = 0;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            off = (y >= 0) ? 18000 * ANG_ONE : -18000 * ANG_ONE;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (y > 0) begin
                nx = x + shr_floor(y, i);
                ny = y - shr_floor(x, i);
                z += atan_table[i];
            end else begin
                nx = x - shr_floor(y, i);
                ny = y + shr_floor(x, i);
                z -= atan_table[i];
            end
            x = nx;
            y = ny;
        end
        return z + off;
    endfunction

    function automatic longint trunc_cd(longint v);
        return (v >= 0) ? v / ANG_ONE : -((-v) / ANG_ONE);
    endfunction

    // event record predicted for one sample
    function automatic t_event predict_event(t_sample smp);
        t_event ev;
        longint alt, azm, ca, sa, cz, sz, px, py, tx, ty, pr;
        bit     prox;
        prox = smp.mode[MODE_PROX];
        alt = smp.alt;
        azm = smp.azm;
        pr = smp.press;
        ev.ts = smp.ts;
        if (smp.legacy) begin
            pr = pr * 4;
            if (pr > 4095) pr = 4095;
            alt = 0;
            azm = 0;
            ev.ts = '0;
        end
        tx = 0;
        ty = 0;
        if (prox && alt != 0) begin
            if (alt > 9000) alt = 9000;
            sin_cos(alt, ca, sa);
            sin_cos(azm, cz, sz);
            if (ca < 0) ca = 0;
            px = shr_floor(sa * cz, 30);
            py = shr_floor(sa * sz, 30);
            tx = trunc_cd(9000 * ANG_ONE - arc_tan2(ca, px));
            ty = trunc_cd(arc_tan2(ca, py) - 9000 * ANG_ONE);
        end
        ev.touch  = smp.mode[MODE_TOUCH];
        ev.pen    = prox & ~smp.mode[MODE_ERASER];
        ev.eraser = prox & smp.mode[MODE_ERASER];
        ev.button = smp.mode[MODE_BUTTON];
        ev.x = smp.x;
        ev.y = smp.y;
        ev.press = pr[11:0];
        ev.tx = tx[14:0];
        ev.ty = ty[14:0];
        return ev;
    endfunction

    function automatic int short_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // receiver stall pattern
    initial begin
        int hold;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_hold) begin
                i_stall <= 1'b1;
                hold = 0;
                while (hold < 3 * LATENCY) begin
                    @(posedge i_clk);
                    hold++;
                end
                i_stall <= 1'b0;
                stall_hold = 1'b0;
            end else if (!stall_quiet && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat (short_gap() + 1) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_event exp_ev;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d", $time, o_pos_x, o_pos_y);
                n_errors++;
            end else begin
                exp_ev = expected_events.pop_front();
                n_checked++;
                if ({o_pen_touch, o_tool_pen, o_tool_eraser, o_barrel_button} !==
                    {exp_ev.touch, exp_ev.pen, exp_ev.eraser, exp_ev.button}) begin
                    $display("%0t: flags expected %b%b%b%b actual %b%b%b%b", $time,
                             exp_ev.touch, exp_ev.pen, exp_ev.eraser, exp_ev.button,
                             o_pen_touch, o_tool_pen, o_tool_eraser, o_barrel_button);
                    n_errors++;
                end
                if (o_pos_x !== exp_ev.x || o_pos_y !== exp_ev.y) begin
                    $display("%0t: pos expected %0d,%0d actual %0d,%0d", $time,
                             exp_ev.x, exp_ev.y, o_pos_x, o_pos_y);
                    n_errors++;
                end
                if (o_pen_pressure !== exp_ev.press) begin
                    $display("%0t: pressure expected %0d actual %0d", $time,
                             exp_ev.press, o_pen_pressure);
                    n_errors++;
                end
                if (o_time_stamp !== exp_ev.ts) begin
                    $display("%0t: timestamp expected %0d actual %0d", $time,
                             exp_ev.ts, o_time_stamp);
                    n_errors++;
                end
                if (o_tilt_x !== exp_ev.tx) begin
                    $display("%0t: tilt_x expected %0d actual %0d", $time,
                             $signed(exp_ev.tx), o_tilt_x);
                    n_errors++;
                end
                if (o_tilt_y !== exp_ev.ty) begin
                    $display("%0t: tilt_y expected %0d actual %0d", $time,
                             $signed(exp_ev.ty), o_tilt_y);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any request moving
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("stylus_sample_to_tilt_events_core_tb failed");
            $finish;
        end
    end

    // send one sample, waiting for it to be taken
    task automatic send_sample(t_sample smp, bit gaps = 1'b1);
        if (gaps && !gap_quiet) begin
            int g;
            g = short_gap();
            if (g > 0) begin
                i_valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
        i_valid         <= 1'b1;
        i_legacy_format <= smp.legacy;
        i_mode_bits     <= smp.mode;
        i_in_x          <= smp.x;
        i_in_y          <= smp.y;
        i_in_pressure   <= smp.press;
        i_altitude      <= smp.alt;
        i_azimuth       <= smp.azm;
        i_in_timestamp  <= smp.ts;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_events.push_back(predict_event(smp));
        n_sent++;
        if (smp.mode[MODE_PROX] && !smp.legacy && smp.alt != 0) n_tilted++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_sample random_sample();
        t_sample smp;
        int pick;
        smp.legacy = ($urandom_range(0, 7) == 0);
        smp.mode   = $urandom_range(0, 15);
        smp.x      = $urandom;
        smp.y      = $urandom;
        smp.press  = $urandom;
        smp.ts     = $urandom;
        pick = $urandom_range(0, 9);
        if (pick == 0) smp.alt = $urandom_range(0, 1) ? 0 : 9000;
        else if (pick == 1) smp.alt = $urandom_range(9001, 16383);
        else smp.alt = $urandom_range(1, 9000);
        pick = $urandom_range(0, 9);
        if (pick == 0) smp.azm = 9000 * $urandom_range(0, 3);
        else if (pick == 1) smp.azm = $urandom_range(36000, 65535);
        else smp.azm = $urandom_range(0, 35999);
        return smp;
    endfunction

    // field extremes, legacy handling and every mode combination
    task automatic test_directed();
        t_sample smp;
        for (int m = 0; m < 16; m++) begin
            smp = '{1'b0, m[3:0], 16'hFFFF * m[0], 16'hFFFF * m[1], 12'(m * 273),
                    14'(m * 600), 16'(m * 2400), 16'(m * 4369)};
            send_sample(smp);
        end
        // legacy pressure saturation and forced-zero angles
        send_sample('{1'b1, 4'hF, 16'h1234, 16'hABCD, 12'hFFF, 14'd4500, 16'd100, 16'hFFFF});
        send_sample('{1'b1, 4'h1, 16'h0, 16'h0, 12'd1023, 14'd0, 16'd0, 16'h5555});
        // altitude above 9000 and all-ones angle fields
        send_sample('{1'b0, 4'h1, 16'h0, 16'h0, 12'h0, 14'h3FFF, 16'hFFFF, 16'h0});
        // straight up: both atan2 operands reach zero only on products
        send_sample('{1'b0, 4'h1, 16'h1, 16'h1, 12'h1, 14'd9000, 16'd0, 16'h1});
        send_sample('{1'b0, 4'h1, 16'h1, 16'h1, 12'h1, 14'd1, 16'd9000, 16'h1});
        send_sample('{1'b0, 4'h9, 16'h2, 16'h2, 12'h2, 14'd9000, 16'd35999, 16'h2});
        send_sample('{1'b0, 4'h1, 16'h2, 16'h2, 12'h2, 14'd4500, 16'd36000, 16'h2});
        drain_results();
    endtask

    // random samples with bursts and stalls, some stretches with no idling
    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            gap_quiet   = (i % 200) >= 150;
            stall_quiet = (i % 200) >= 170;
            send_sample(random_sample());
        end
        gap_quiet = 1'b0;
        stall_quiet = 1'b0;
        drain_results();
    endtask

    // receiver holds off while the sender keeps offering, filling the pipeline
    task automatic test_backpressure();
        stall_quiet = 1'b1;
        gap_quiet = 1'b1;
        stall_hold = 1'b1;
        for (int i = 0; i < 2 * LATENCY; i++) send_sample(random_sample(), 1'b0);
        gap_quiet = 1'b0;
        stall_quiet = 1'b0;
        drain_results();
    endtask

    initial begin
        int tail;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_tilted = 0;
        idle_cycles = 0;
        stall_hold = 1'b0;
        stall_quiet = 1'b0;
        gap_quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_legacy_format = 1'b0;
        i_mode_bits = '0;
        i_in_x = '0;
        i_in_y = '0;
        i_in_pressure = '0;
        i_altitude = '0;
        i_azimuth = '0;
        i_in_timestamp = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random(900);

        tail = 0;
        while (tail < LATENCY + 10) begin
            @(posedge i_clk);
            tail++;
        end
        $display("covered %0d samples, %0d with tilt computed, %0d results checked",
                 n_sent, n_tilted, n_checked);
        $display("included legacy, saturation, wrapped angles and a long receiver hold-off");
        if (n_errors == 0 && expected_events.size() == 0)
            $display("stylus_sample_to_tilt_events_core_tb passed");
        else
            $display("stylus_sample_to_tilt_events_core_tb failed");
        $finish;
    end

endmodule
